[rtl/clhm_pkg.sv]
// shared types, register map and codes of the control loop health monitor
package clhm_pkg;

	// configuration port geometry
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// default length of the error sign window
	localparam int SIGN_WINDOW_DEF = 8;

	// register indexes, at byte address 4*index
	localparam logic [2:0] REG_STUCK_LIMIT   = 3'd0;
	localparam logic [2:0] REG_DIVERGE_THR   = 3'd1;
	localparam logic [2:0] REG_OSC_LIMIT     = 3'd2;
	localparam logic [2:0] REG_STILL_BAND    = 3'd3;
	localparam logic [2:0] REG_DROPOUT_LIMIT = 3'd4;
	localparam logic [2:0] REG_STEADY_THR    = 3'd5;
	localparam logic [2:0] REG_SETTLE_LIMIT  = 3'd6;

	// register reset values
	localparam logic [31:0] RST_STUCK_LIMIT   = 32'd1000000;
	localparam logic [31:0] RST_DIVERGE_THR   = 32'd655360;
	localparam logic [2:0]  RST_OSC_LIMIT     = 3'd4;
	localparam logic [31:0] RST_STILL_BAND    = 32'd66;
	localparam logic [31:0] RST_DROPOUT_LIMIT = 32'd1000000;
	localparam logic [31:0] RST_STEADY_THR    = 32'd6554;
	localparam logic [31:0] RST_SETTLE_LIMIT  = 32'd5000000;

	// sign window entry codes
	localparam logic [1:0] SIGN_EMPTY = 2'd0;
	localparam logic [1:0] SIGN_POS   = 2'd1;
	localparam logic [1:0] SIGN_NEG   = 2'd2;

	// status bit positions
	localparam int ST_STUCK   = 0;
	localparam int ST_DIVERGE = 1;
	localparam int ST_OSC     = 2;
	localparam int ST_DROPOUT = 3;
	localparam int ST_UNREACH = 4;

	// command codes
	localparam logic CMD_EVAL  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic [31:0] stuck_limit;
		logic [31:0] diverge_thr;
		logic [2:0]  osc_limit;
		logic [31:0] still_band;
		logic [31:0] dropout_limit;
		logic [31:0] steady_thr;
		logic [31:0] settle_limit;
	} cfg_t;

	typedef struct packed {
		logic               command;
		logic signed [31:0] setpoint;
		logic signed [31:0] measurement;
		logic signed [31:0] drive_output;
		logic [23:0]        time_step;
	} sample_t;

	typedef struct packed {
		logic       fault;
		logic [4:0] status;
		logic [4:0] newly_set;
	} result_t;

endpackage

[rtl/control_loop_health_monitor.sv]
// top level of the control loop health monitor
//
// Sample channel (sample_valid/sample_ready) carries one word per control
// period: command, setpoint, measurement, drive_output and time_step.
// Result channel (result_valid/result_ready) returns one word per sample:
// fault, sticky status and the status bits newly set by that sample.
// Registers are to be written over the apb-style port only while the block is
// idle; the block itself does not enforce this. A word is taken into an input
// register and evaluated once the result register is free or being emptied;
// its result is loaded into the output register, with result_valid, at the end
// of that cycle. Throughput, set by the combinational per-sample state update
// (timers, sign window, history), is one word per cycle while results are taken.
// While the receiver stalls, the result holds and one more word is still
// taken into the input register; then sample_ready drops until it drains.
// Reset clears the status, timers, sign window, history and both pipeline
// registers, and loads the register defaults. A clear command does the
// same to the state but keeps the registers.
module control_loop_health_monitor #(
	parameter int SIGN_WINDOW = clhm_pkg::SIGN_WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [clhm_pkg::ADDR_W-1:0] paddr,
	input  logic [clhm_pkg::DATA_W-1:0] pwdata,
	output logic [clhm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic                        command,
	input  logic signed [31:0]          setpoint,
	input  logic signed [31:0]          measurement,
	input  logic signed [31:0]          drive_output,
	input  logic [23:0]                 time_step,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        fault,
	output logic [4:0]                  status,
	output logic [4:0]                  newly_set
);
	import clhm_pkg::*;

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	logic    adv;
	result_t res;
	result_t res_s2;
	logic    valid_s2;

	assign pready = 1'b1;

	clhm_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	// evaluate when the result register is free or being emptied
	assign adv          = valid_s1 & (~valid_s2 | result_ready);
	assign sample_ready = ~valid_s1 | adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			smp_s1.command      <= command;
			smp_s1.setpoint     <= setpoint;
			smp_s1.measurement  <= measurement;
			smp_s1.drive_output <= drive_output;
			smp_s1.time_step    <= time_step;
		end
	end

	clhm_core #(.SIGN_WINDOW(SIGN_WINDOW)) u_core (
		.clk(clk), .arst_n(arst_n), .step(adv), .smp(smp_s1), .cfg(cfg), .res(res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign fault        = res_s2.fault;
	assign status       = res_s2.status;
	assign newly_set    = res_s2.newly_set;

endmodule

[rtl/clhm_cfg.sv]
// configuration register file behind the apb-style port
module clhm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [clhm_pkg::ADDR_W-1:0]    paddr,
	input  logic [clhm_pkg::DATA_W-1:0]    pwdata,
	output logic [clhm_pkg::DATA_W-1:0]    prdata,
	output clhm_pkg::cfg_t                 cfg
);
	import clhm_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// register writes, indexes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stuck_limit   <= RST_STUCK_LIMIT;
			cfg_q.diverge_thr   <= RST_DIVERGE_THR;
			cfg_q.osc_limit     <= RST_OSC_LIMIT;
			cfg_q.still_band    <= RST_STILL_BAND;
			cfg_q.dropout_limit <= RST_DROPOUT_LIMIT;
			cfg_q.steady_thr    <= RST_STEADY_THR;
			cfg_q.settle_limit  <= RST_SETTLE_LIMIT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STUCK_LIMIT:   cfg_q.stuck_limit   <= pwdata;
				REG_DIVERGE_THR:   cfg_q.diverge_thr   <= pwdata;
				REG_OSC_LIMIT:     cfg_q.osc_limit     <= pwdata[2:0];
				REG_STILL_BAND:    cfg_q.still_band    <= pwdata;
				REG_DROPOUT_LIMIT: cfg_q.dropout_limit <= pwdata;
				REG_STEADY_THR:    cfg_q.steady_thr    <= pwdata;
				REG_SETTLE_LIMIT:  cfg_q.settle_limit  <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_STUCK_LIMIT:   prdata = cfg_q.stuck_limit;
			REG_DIVERGE_THR:   prdata = cfg_q.diverge_thr;
			REG_OSC_LIMIT:     prdata = {29'd0, cfg_q.osc_limit};
			REG_STILL_BAND:    prdata = cfg_q.still_band;
			REG_DROPOUT_LIMIT: prdata = cfg_q.dropout_limit;
			REG_STEADY_THR:    prdata = cfg_q.steady_thr;
			REG_SETTLE_LIMIT:  prdata = cfg_q.settle_limit;
			default:           prdata = '0;
		endcase
	end

endmodule

[rtl/clhm_timer.sv]
// saturating microsecond timer with half-sample-biased limit test
module clhm_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  logic        clr,
	input  logic        moved,
	input  logic [23:0] dt,
	input  logic [31:0] limit,
	output logic        pass
);
	logic [31:0] timer_q;
	logic [32:0] sum;
	logic [31:0] timer_nx;
	logic [33:0] lhs;
	logic [33:0] rhs;

	// restart on movement, else accumulate and saturate
	always_comb begin
		sum      = {1'b0, timer_q} + {9'd0, dt};
		timer_nx = moved ? 32'd0 : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
		lhs      = {1'b0, timer_nx, 1'b0} + {10'd0, dt};
		rhs      = {1'b0, limit, 1'b0};
		pass     = lhs >= rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else if (clr) begin
			timer_q <= '0;
		end else if (upd) begin
			timer_q <= timer_nx;
		end
	end

endmodule

[rtl/clhm_core.sv]
// per-sample evaluation: error, history, sign window and sticky status
module clhm_core #(
	parameter int SIGN_WINDOW = clhm_pkg::SIGN_WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  clhm_pkg::sample_t smp,
	input  clhm_pkg::cfg_t    cfg,
	output clhm_pkg::result_t res
);
	import clhm_pkg::*;

	localparam int PTR_W = $clog2(SIGN_WINDOW);
	localparam int CNT_W = $clog2(SIGN_WINDOW + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SIGN_WINDOW - 1);

	logic               hist_q;
	logic signed [32:0] last_err_q;
	logic signed [31:0] last_meas_q;
	logic signed [31:0] last_sp_q;
	logic signed [31:0] last_drive_q;
	logic [4:0]         status_q;
	logic [1:0]         win_q [SIGN_WINDOW];
	logic [PTR_W-1:0]   ptr_q;

	logic               is_clear;
	logic               zero_dt;
	logic               upd;
	logic               clr;
	logic signed [32:0] err;
	logic [32:0]        err_abs;
	logic signed [33:0] de;
	logic signed [32:0] mdiff;
	logic [32:0]        mdiff_abs;
	logic               drive_moved;
	logic               meas_moved;
	logic               stepped;
	logic               stuck_pass;
	logic               drop_pass;
	logic               settle_pass;
	logic               diverge;
	logic               osc;
	logic               unreach;
	logic [1:0]         code;
	logic [1:0]         win_nx [SIGN_WINDOW];
	logic [PTR_W-1:0]   ptr_nx;
	logic [CNT_W-1:0]   chg_cnt;
	logic [4:0]         status_nx;

	assign is_clear = smp.command == CMD_CLEAR;
	assign zero_dt  = smp.time_step == 24'd0;
	assign upd      = step & ~is_clear & ~zero_dt;
	assign clr      = step & is_clear;

	// error and its change against the previous sample
	always_comb begin
		err       = {smp.setpoint[31], smp.setpoint} - {smp.measurement[31], smp.measurement};
		err_abs   = err[32] ? 33'(-err) : 33'(err);
		de        = {err[32], err} - {last_err_q[32], last_err_q};
		mdiff     = {smp.measurement[31], smp.measurement} - {last_meas_q[31], last_meas_q};
		mdiff_abs = mdiff[32] ? 33'(-mdiff) : 33'(mdiff);
	end

	// movement detectors
	assign drive_moved = hist_q && (smp.drive_output != last_drive_q);
	assign meas_moved  = hist_q && (mdiff_abs >= {1'b0, cfg.still_band});
	assign stepped     = hist_q && (smp.setpoint != last_sp_q);

	clhm_timer u_stuck (
		.clk(clk), .arst_n(arst_n), .upd(upd), .clr(clr), .moved(drive_moved),
		.dt(smp.time_step), .limit(cfg.stuck_limit), .pass(stuck_pass)
	);

	clhm_timer u_dropout (
		.clk(clk), .arst_n(arst_n), .upd(upd), .clr(clr), .moved(meas_moved),
		.dt(smp.time_step), .limit(cfg.dropout_limit), .pass(drop_pass)
	);

	clhm_timer u_settle (
		.clk(clk), .arst_n(arst_n), .upd(upd), .clr(clr), .moved(stepped),
		.dt(smp.time_step), .limit(cfg.settle_limit), .pass(settle_pass)
	);

	// diverging: large error moving further from zero
	assign diverge = (err_abs > {1'b0, cfg.diverge_thr}) &&
		((!err[32] && (err != '0) && !de[33] && (de != '0)) || (err[32] && de[33]));

	// sign window after writing this sample's code
	assign code   = err[32] ? SIGN_NEG : SIGN_POS;
	assign ptr_nx = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;

	always_comb begin
		for (int j = 0; j < SIGN_WINDOW; j++) begin
			win_nx[j] = (PTR_W'(j) == ptr_q) ? code : win_q[j];
		end
	end

	// sign changes over adjacent pairs, skipping the newest-to-oldest wrap
	always_comb begin
		chg_cnt = '0;
		for (int j = 0; j < SIGN_WINDOW; j++) begin
			if ((PTR_W'(j) != ptr_q) && (win_nx[j] != SIGN_EMPTY) &&
				(win_nx[j] != win_nx[(j + 1) % SIGN_WINDOW])) begin
				chg_cnt = chg_cnt + CNT_W'(1);
			end
		end
	end

	assign osc     = 32'(chg_cnt) > {29'd0, cfg.osc_limit};
	assign unreach = settle_pass && (err_abs > {1'b0, cfg.steady_thr});

	always_comb begin
		status_nx = status_q;
		if (stuck_pass) status_nx[ST_STUCK]   = 1'b1;
		if (diverge)    status_nx[ST_DIVERGE] = 1'b1;
		if (osc)        status_nx[ST_OSC]     = 1'b1;
		if (drop_pass)  status_nx[ST_DROPOUT] = 1'b1;
		if (unreach)    status_nx[ST_UNREACH] = 1'b1;
	end

	// result word for this sample
	always_comb begin
		priority if (is_clear) begin
			res.fault     = 1'b0;
			res.status    = '0;
			res.newly_set = '0;
		end else if (zero_dt) begin
			res.fault     = 1'b1;
			res.status    = status_q;
			res.newly_set = '0;
		end else begin
			res.fault     = 1'b0;
			res.status    = status_nx;
			res.newly_set = status_nx & ~status_q;
		end
	end

	// history and status state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q       <= 1'b0;
			last_err_q   <= '0;
			last_meas_q  <= '0;
			last_sp_q    <= '0;
			last_drive_q <= '0;
			status_q     <= '0;
			ptr_q        <= '0;
			for (int j = 0; j < SIGN_WINDOW; j++) win_q[j] <= SIGN_EMPTY;
		end else if (clr) begin
			hist_q       <= 1'b0;
			last_err_q   <= '0;
			last_meas_q  <= '0;
			last_sp_q    <= '0;
			last_drive_q <= '0;
			status_q     <= '0;
			ptr_q        <= '0;
			for (int j = 0; j < SIGN_WINDOW; j++) win_q[j] <= SIGN_EMPTY;
		end else if (upd) begin
			hist_q       <= 1'b1;
			last_err_q   <= err;
			last_meas_q  <= smp.measurement;
			last_sp_q    <= smp.setpoint;
			last_drive_q <= smp.drive_output;
			status_q     <= status_nx;
			ptr_q        <= ptr_nx;
			for (int j = 0; j < SIGN_WINDOW; j++) win_q[j] <= win_nx[j];
		end
	end

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench of the control loop health monitor: predictor, stimulus and checks
`timescale 1ns / 1ps

module tb_top;
	import clhm_pkg::*;

	localparam int     ITEMS_PER_ROUND = 92;
	localparam int     STALL_LIMIT     = 5000;
	localparam int     HOLD_CYCLES     = 300;
	localparam longint Q_MAX           = 64'sd2147483647;
	localparam longint Q_MIN           = -64'sd2147483648;

	typedef enum logic [1:0] {
		SHAPE_SETTLE,
		SHAPE_RING,
		SHAPE_RUNAWAY,
		SHAPE_FROZEN
	} shape_e;

	// block ports
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	logic                command = CMD_EVAL;
	logic signed [31:0]  setpoint = '0;
	logic signed [31:0]  measurement = '0;
	logic signed [31:0]  drive_output = '0;
	logic [23:0]         time_step = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic                fault;
	logic [4:0]          status;
	logic [4:0]          newly_set;

	// traffic shaping
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// bookkeeping
	result_t expected_health[$];
	int      fail_count = 0;
	int      n_samples = 0;
	int      n_clears = 0;
	int      n_faults = 0;
	int      n_results = 0;
	int      latch_hits[5] = '{default: 0};

	// predictor copy of registers and state
	cfg_t          cfg;
	logic [31:0]   stuck_tmr;
	logic [31:0]   drop_tmr;
	logic [31:0]   settle_tmr;
	logic [1:0]    sign_win[SIGN_WINDOW_DEF];
	int            win_ptr;
	longint        prev_err;
	longint        prev_meas;
	longint        prev_drive;
	bit            hist_ok;
	logic [4:0]    sticky;

	control_loop_health_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.command(command),
		.setpoint(setpoint),
		.measurement(measurement),
		.drive_output(drive_output),
		.time_step(time_step),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.fault(fault),
		.status(status),
		.newly_set(newly_set)
	);

	// clock
	always #2 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void reseed_history();
		stuck_tmr = '0;
		drop_tmr = '0;
		settle_tmr = '0;
		for (int i = 0; i < SIGN_WINDOW_DEF; i++) sign_win[i] = SIGN_EMPTY;
		win_ptr = 0;
		prev_err = 0;
		prev_meas = 0;
		prev_drive = 0;
		hist_ok = 1'b0;
		sticky = '0;
	endfunction

	// saturating microsecond timer, cleared on movement
	function automatic logic [31:0] timer_next(logic [31:0] tmr, bit moved, logic [23:0] dt);
		logic [32:0] sum;
		sum = {1'b0, tmr} + {9'b0, dt};
		if (moved) return '0;
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// timer test with half a sample of bias
	function automatic bit timer_due(logic [31:0] tmr, logic [23:0] dt, logic [31:0] lim);
		return (64'(tmr) * 2 + 64'(dt)) >= (64'(lim) * 2);
	endfunction

	function automatic result_t predict_health(sample_t s);
		result_t    res;
		longint     sp, ms, dr, err, derr, mag, dmeas;
		logic [4:0] held;
		logic [1:0] older, newer;
		bit         stuck_hit, div_hit, osc_hit, drop_hit, unr_hit;
		int         changes;
		res = '0;
		if (s.command == CMD_CLEAR) begin
			reseed_history();
			n_clears++;
			return res;
		end
		if (s.time_step == 24'd0) begin
			res.fault = 1'b1;
			res.status = sticky;
			n_faults++;
			return res;
		end
		sp = longint'($signed(s.setpoint));
		ms = longint'($signed(s.measurement));
		dr = longint'($signed(s.drive_output));
		err = sp - ms;
		mag = (err < 0) ? -err : err;
		held = sticky;

		// stuck drive
		stuck_tmr = timer_next(stuck_tmr, hist_ok && (dr != prev_drive), s.time_step);
		stuck_hit = timer_due(stuck_tmr, s.time_step, cfg.stuck_limit);

		// diverging error
		derr = err - prev_err;
		div_hit = (mag > longint'(cfg.diverge_thr)) &&
			((err > 0 && derr > 0) || (err < 0 && derr < 0));

		// sign changes across the window, oldest to newest
		sign_win[win_ptr] = (err >= 0) ? SIGN_POS : SIGN_NEG;
		win_ptr = (win_ptr + 1) % SIGN_WINDOW_DEF;
		changes = 0;
		for (int i = 0; i < SIGN_WINDOW_DEF - 1; i++) begin
			older = sign_win[(win_ptr + i) % SIGN_WINDOW_DEF];
			newer = sign_win[(win_ptr + i + 1) % SIGN_WINDOW_DEF];
			if (older != SIGN_EMPTY && older != newer) changes++;
		end
		osc_hit = changes > int'(cfg.osc_limit);

		// sensor dropout
		dmeas = ms - prev_meas;
		if (dmeas < 0) dmeas = -dmeas;
		drop_tmr = timer_next(drop_tmr, hist_ok && (dmeas >= longint'(cfg.still_band)),
			s.time_step);
		drop_hit = timer_due(drop_tmr, s.time_step, cfg.dropout_limit);

		// unreachable setpoint, timed from the last setpoint step
		settle_tmr = timer_next(settle_tmr, hist_ok && (sp != prev_err + prev_meas),
			s.time_step);
		unr_hit = timer_due(settle_tmr, s.time_step, cfg.settle_limit) &&
			(mag > longint'(cfg.steady_thr));

		sticky[ST_STUCK] = sticky[ST_STUCK] | stuck_hit;
		sticky[ST_DIVERGE] = sticky[ST_DIVERGE] | div_hit;
		sticky[ST_OSC] = sticky[ST_OSC] | osc_hit;
		sticky[ST_DROPOUT] = sticky[ST_DROPOUT] | drop_hit;
		sticky[ST_UNREACH] = sticky[ST_UNREACH] | unr_hit;

		prev_err = err;
		prev_meas = ms;
		prev_drive = dr;
		hist_ok = 1'b1;

		res.status = sticky;
		res.newly_set = sticky & ~held;
		for (int b = 0; b < 5; b++) if (res.newly_set[b]) latch_hits[b]++;
		return res;
	endfunction

	// ---------------------------------------------------------------- receiver side

	// result ready with random stalls and an occasional long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (expected_health.size() == 0) begin
				fail_count++;
				$display("%0t: result word with nothing expected (fault %0d status %0h new %0h)",
					$time, fault, status, newly_set);
			end else begin
				want = expected_health.pop_front();
				if (fault !== want.fault) begin
					fail_count++;
					$display("%0t: fault expected %0d actual %0d", $time, want.fault, fault);
				end
				if (status !== want.status) begin
					fail_count++;
					$display("%0t: status expected %05b actual %05b", $time, want.status, status);
				end
				if (newly_set !== want.newly_set) begin
					fail_count++;
					$display("%0t: newly_set expected %05b actual %05b",
						$time, want.newly_set, newly_set);
				end
			end
		end
	end

	// no handshake of any kind for too long ends the run
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("control_loop_health_monitor test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sender side

	function automatic sample_t mk_sample(logic cmd, logic [31:0] sp, logic [31:0] ms,
			logic [31:0] dr, logic [23:0] dt);
		sample_t s;
		s.command = cmd;
		s.setpoint = sp;
		s.measurement = ms;
		s.drive_output = dr;
		s.time_step = dt;
		return s;
	endfunction

	// offer one word, hold it until taken, then predict its result
	task automatic send_sample(sample_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		command <= s.command;
		setpoint <= s.setpoint;
		measurement <= s.measurement;
		drive_output <= s.drive_output;
		time_step <= s.time_step;
		do @(posedge clk); while (!sample_ready);
		expected_health.push_back(predict_health(s));
		n_samples++;
	endtask

	// stop offering and let every expected result drain
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (expected_health.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup then access, psel stays up across a batch
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_STUCK_LIMIT:   cfg.stuck_limit = val;
			REG_DIVERGE_THR:   cfg.diverge_thr = val;
			REG_OSC_LIMIT:     cfg.osc_limit = val[2:0];
			REG_STILL_BAND:    cfg.still_band = val;
			REG_DROPOUT_LIMIT: cfg.dropout_limit = val;
			REG_STEADY_THR:    cfg.steady_thr = val;
			REG_SETTLE_LIMIT:  cfg.settle_limit = val;
			default: ;
		endcase
	endtask

	task automatic load_config(logic [31:0] stuck_lim, logic [31:0] div_thr,
			logic [31:0] osc_lim, logic [31:0] still_band, logic [31:0] drop_lim,
			logic [31:0] steady_thr, logic [31:0] settle_lim);
		wait_idle();
		write_reg(REG_STUCK_LIMIT, stuck_lim);
		write_reg(REG_DIVERGE_THR, div_thr);
		write_reg(REG_OSC_LIMIT, osc_lim);
		write_reg(REG_STILL_BAND, still_band);
		write_reg(REG_DROPOUT_LIMIT, drop_lim);
		write_reg(REG_STEADY_THR, steady_thr);
		write_reg(REG_SETTLE_LIMIT, settle_lim);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(9))
			0: return 32'd1;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3, 4, 5: return $urandom_range(1, 5000);
			default: return $urandom_range(5000, 200000);
		endcase
	endfunction

	function automatic logic [31:0] pick_threshold();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3, 4, 5: return $urandom_range(0, 1 << 16);
			default: return $urandom_range(1 << 16, 1 << 24);
		endcase
	endfunction

	function automatic longint jitter(int n);
		return longint'($urandom_range(0, 2 * n)) - n;
	endfunction

	function automatic longint clamp_q(longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	function automatic longint rand_level();
		if ($urandom_range(99) < 25) return longint'($signed($urandom));
		return jitter(1 << $urandom_range(8, 24));
	endfunction

	// mostly short control periods, some zero, some huge
	function automatic logic [23:0] rand_step();
		int r;
		r = $urandom_range(99);
		if (r < 4) return 24'd0;
		if (r < 10) return 24'($urandom);
		if (r < 20) return 24'd1;
		return 24'($urandom_range(1, 3000));
	endfunction

	function automatic sample_t noise_sample();
		return mk_sample(($urandom_range(99) < 10) ? CMD_CLEAR : CMD_EVAL, $urandom, $urandom,
			$urandom, ($urandom_range(99) < 15) ? 24'd0 : 24'($urandom));
	endfunction

	function automatic sample_t clear_sample();
		return mk_sample(CMD_CLEAR, $urandom, $urandom, $urandom, 24'($urandom));
	endfunction

	// a run of plausible loop behavior with random content
	task automatic run_episode(int len);
		shape_e shape;
		longint sp, ms, dr, amp;
		int     dir;
		shape = shape_e'($urandom_range(3));
		sp = rand_level();
		ms = rand_level();
		dr = rand_level();
		amp = longint'($urandom_range(1, 1 << $urandom_range(4, 20)));
		dir = ($urandom_range(1) == 1) ? 1 : -1;
		repeat (len) begin
			// occasional setpoint step
			if ($urandom_range(99) < 8) sp = rand_level();
			case (shape)
				SHAPE_SETTLE: ms = ms + (sp - ms) / 4 + jitter(200);
				SHAPE_RING: begin
					ms = sp + dir * amp;
					if ($urandom_range(99) < 85) dir = -dir;
				end
				SHAPE_RUNAWAY: begin
					ms = ms - dir * amp;
					if (amp < (64'sd1 << 30)) amp = amp * 2;
				end
				default: ms = ms + jitter(2);
			endcase
			ms = clamp_q(ms);
			// a frozen loop rarely moves its drive
			if ($urandom_range(99) < ((shape == SHAPE_FROZEN) ? 10 : 60))
				dr = clamp_q(dr + jitter(4096));
			send_sample(mk_sample(CMD_EVAL, sp[31:0], ms[31:0], dr[31:0], rand_step()));
		end
	endtask

	// ---------------------------------------------------------------- tests

	// field extremes, both commands, zero step on fresh and latched state
	task automatic test_directed();
		send_sample(mk_sample(CMD_EVAL, 32'd0, 32'd0, 32'd0, 24'd0));
		send_sample(mk_sample(CMD_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF));
		send_sample(mk_sample(CMD_EVAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF));
		send_sample(mk_sample(CMD_EVAL, 32'd0, 32'd0, 32'd0, 24'd0));
		send_sample(mk_sample(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
		send_sample(mk_sample(CMD_EVAL, 32'h0001_0000, 32'd0, 32'h1234, 24'd1));
		// alternating error sign drives the oscillation count
		for (int i = 0; i < 10; i++)
			send_sample(mk_sample(CMD_EVAL, 32'd0, (i % 2 == 1) ? 32'h0002_0000 : -32'sh2_0000,
				32'(i), 24'd1));
		// error running away
		send_sample(mk_sample(CMD_EVAL, 32'd0, -32'sh10_0000, 32'd9, 24'd1));
		send_sample(mk_sample(CMD_EVAL, 32'd0, -32'sh20_0000, 32'd9, 24'd1));
		send_sample(mk_sample(CMD_CLEAR, 32'd0, 32'd0, 32'd0, 24'd0));
		send_sample(mk_sample(CMD_EVAL, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 24'hAA_AAAA));
		send_sample(mk_sample(CMD_EVAL, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 24'h55_5555));
	endtask

	// zero time limits always pass; an oscillation limit of 7 never trips
	task automatic test_limit_corners();
		load_config(32'd0, 32'd0, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_sample(clear_sample());
		for (int i = 0; i < 10; i++)
			send_sample(mk_sample(CMD_EVAL, 32'd0, (i % 2 == 1) ? 32'd500 : -32'sd500, 32'd7,
				24'd1));
	endtask

	// timers must saturate rather than wrap under long quiet stretches
	task automatic test_timer_saturation();
		load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'hFFFF_FFFF, 32'd1000,
			32'hFFFF_FFFF);
		send_sample(clear_sample());
		for (int i = 0; i < 300; i++)
			send_sample(mk_sample(CMD_EVAL, 32'd0, (i % 2 == 1) ? 32'd10 : -32'sd10, 32'd3,
				24'hFF_FFFF));
		send_sample(mk_sample(CMD_EVAL, 32'd0, 32'd100000, 32'd3, 24'd1));
		send_sample(mk_sample(CMD_EVAL, 32'd0, 32'd100000, 32'd3, 24'hFF_FFFF));
	endtask

	// random episodes and noise under one idle pattern, four register settings
	task automatic test_random_traffic(int snd_pct, int rcv_pct, int phase);
		int start;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int round = 0; round < 4; round++) begin
			if (phase == 0 && round == 0)
				load_config('1, '1, 32'd7, '1, '1, '1, '1);
			else if (phase == 0 && round == 1)
				load_config(32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1);
			else
				load_config(pick_limit(), pick_threshold(), $urandom_range(7), pick_threshold(),
					pick_limit(), pick_threshold(), pick_limit());
			start = n_samples;
			while (n_samples - start < ITEMS_PER_ROUND) begin
				if ($urandom_range(99) < 15)
					send_sample(noise_sample());
				else
					run_episode($urandom_range(4, 40));
				if ($urandom_range(99) < 35) send_sample(clear_sample());
			end
		end
	endtask

	// receiver holds off while words keep coming, so the input stalls
	task automatic test_backpressure();
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = HOLD_CYCLES;
		run_episode(40);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		cfg.stuck_limit = RST_STUCK_LIMIT;
		cfg.diverge_thr = RST_DIVERGE_THR;
		cfg.osc_limit = RST_OSC_LIMIT;
		cfg.still_band = RST_STILL_BAND;
		cfg.dropout_limit = RST_DROPOUT_LIMIT;
		cfg.steady_thr = RST_STEADY_THR;
		cfg.settle_limit = RST_SETTLE_LIMIT;
		reseed_history();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 12;
		recv_idle_pct = 69;
		test_directed();
		test_limit_corners();
		test_timer_saturation();
		test_random_traffic(12, 69, 0);
		test_random_traffic(69, 12, 1);
		test_random_traffic(0, 0, 2);
		test_backpressure();

		wait_idle();
		repeat (4) @(posedge clk);
		if (expected_health.size() != 0) begin
			fail_count++;
			$display("%0t: %0d results never arrived", $time, expected_health.size());
		end
		$display("ran %0d samples (%0d clears, %0d zero-step faults), %0d result words checked",
			n_samples, n_clears, n_faults, n_results);
		$display("bits latched: stuck %0d diverging %0d oscillating %0d dropout %0d unreachable %0d",
			latch_hits[ST_STUCK], latch_hits[ST_DIVERGE], latch_hits[ST_OSC],
			latch_hits[ST_DROPOUT], latch_hits[ST_UNREACH]);
		if (fail_count == 0)
			$display("control_loop_health_monitor test passed");
		else
			$display("control_loop_health_monitor test failed");
		$finish;
	end

endmodule
